// File: rtl/bcomp_pkg.sv
// Shared widths, constants and types for the barometer compensation pipeline.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bcomp_pkg;

    // Item and register widths
    localparam int RAW_W     = 24;
    localparam int PRES_W    = 32;
    localparam int TEMP_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int C12_W     = 12;
    localparam int C20_W     = 20;
    localparam int C16_W     = 16;

    // Pipeline depth
    localparam int NSTG = 10;

    // Q30 fixed point
    localparam int FRAC_W = 30;
    localparam int Q_W    = 32;
    localparam logic signed [31:0] HALF_Q = 32'sd536870912;   // 2^29

    // Raw scaling: round(raw * 2^11 / 15) = 136*|raw| + floor((8*|raw| + 7) / 15)
    localparam int DIVY_W   = RAW_W + 3;
    localparam int RECIP_W  = 28;
    localparam int RECIP_SH = 31;
    localparam logic [RECIP_W-1:0] RECIP = 28'd143165577;     // ceil(2^31 / 15)
    localparam int QUO_W    = 23;
    localparam int BASE_W   = Q_W - 1;

    // Polynomial term widths
    localparam int S2_W  = 48;
    localparam int S1_W  = 51;
    localparam int R1_W  = 48;
    localparam int S0_W  = 52;
    localparam int R0_W  = 49;
    localparam int SUM_W = 53;

    // Temperature path
    localparam int TPROD_W = C12_W + Q_W;
    localparam int TACC_W  = 44;
    localparam int T_C0_SH = 29;
    localparam int T_SH    = 22;
    localparam logic signed [31:0] T_HALF = 32'sd2097152;     // 2^21

    // Pressure output rounding
    localparam int P_SH = 26;
    localparam logic signed [31:0] P_HALF = 32'sd33554432;    // 2^25

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_OFS_SLOPE = 3'd0,
        CFG_PRES_OFFSET    = 3'd1,
        CFG_PRES_LINEAR    = 3'd2,
        CFG_TEMP_CROSS_LIN = 3'd3,
        CFG_CROSS_FIRST    = 3'd4,
        CFG_PRES_SQUARE    = 3'd5,
        CFG_CROSS_SECOND   = 3'd6,
        CFG_PRES_CUBE      = 3'd7
    } cfg_idx_t;

    // Load enables of a two-stage unit
    typedef struct packed {
        logic prod;
        logic fin;
    } en2_t;

endpackage

`default_nettype wire

// File: rtl/bcomp_flow.sv
// Valid bits and per-stage load enables of the compensation pipeline.
// Depends on bcomp_pkg.
`default_nettype none

module bcomp_flow (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      out_ready,
    output logic                      in_ready,
    output logic                      out_valid,
    output logic [bcomp_pkg::NSTG:1]  en
);
    import bcomp_pkg::*;

    logic [NSTG:1] v_reg;
    logic [NSTG:1] v_next;

    // A stage loads when the sink takes the item or it or any later stage is empty
    always_comb
    begin
        for (int k = 1; k <= NSTG; k++)
        begin
            en[k] = out_ready || (((~v_reg) >> (k - 1)) != '0);
        end
        v_next = v_reg;
        if (en[1])
        begin
            v_next[1] = in_valid;
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[NSTG];

endmodule

`default_nettype wire

// File: rtl/bcomp_scale.sv
// Two-stage conversion of a raw 24-bit reading to Q30 (raw * 2^11 / 15, rounded).
// Depends on bcomp_pkg.
`default_nettype none

module bcomp_scale (
    input  logic                                  clk,
    input  bcomp_pkg::en2_t                       en,
    input  logic signed [bcomp_pkg::RAW_W-1:0]    raw,
    output logic signed [bcomp_pkg::Q_W-1:0]      q
);
    import bcomp_pkg::*;

    localparam int PROD_W = DIVY_W + RECIP_W;

    logic [RAW_W-1:0]      mag_in;
    logic [DIVY_W-1:0]     divy;
    logic [PROD_W-1:0]     prod;
    logic [QUO_W-1:0]      quo_next;
    logic [QUO_W-1:0]      quo_reg;
    logic [BASE_W-1:0]     base_next;
    logic [BASE_W-1:0]     base_reg;
    logic                  neg_reg;
    logic [BASE_W-1:0]     mag;
    logic [Q_W-1:0]        mag_ext;
    logic signed [Q_W-1:0] q_next;
    logic signed [Q_W-1:0] q_reg;

    // Stage 1: magnitude, 136*|raw| by shift-add, remainder part by reciprocal
    always_comb
    begin
        mag_in    = raw[RAW_W-1] ? RAW_W'(-raw) : raw;
        divy      = {mag_in, 3'b111};
        prod      = PROD_W'(divy) * PROD_W'(RECIP);
        quo_next  = prod[RECIP_SH+QUO_W-1:RECIP_SH];
        base_next = BASE_W'({mag_in, 7'b0}) + BASE_W'({mag_in, 3'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            quo_reg  <= quo_next;
            base_reg <= base_next;
            neg_reg  <= raw[RAW_W-1];
        end
    end

    // Stage 2: combine and restore sign
    always_comb
    begin
        mag     = base_reg + BASE_W'(quo_reg);
        mag_ext = {1'b0, mag};
        q_next  = neg_reg ? -mag_ext : mag_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en.fin)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// File: rtl/bcomp_mulq30.sv
// Two-stage Q30 multiply y = round(x * p / 2^30) + addend * 2^30, ties away from zero.
// x is split into two partial products. Depends on bcomp_pkg.
`default_nettype none

module bcomp_mulq30 #(
    parameter int XW = 48,
    parameter int PW = 32,
    parameter int AW = 20,
    parameter int OW = 51
) (
    input  logic                   clk,
    input  bcomp_pkg::en2_t        en,
    input  logic signed [XW-1:0]   x,
    input  logic signed [PW-1:0]   p,
    input  logic signed [AW-1:0]   addend,
    output logic signed [OW-1:0]   y
);
    import bcomp_pkg::*;

    localparam int LW  = XW / 2;
    localparam int HW  = XW - LW;
    localparam int PLW = LW + 1 + PW;
    localparam int PHW = HW + PW;
    localparam int SW  = ((XW + PW > AW + 2 * FRAC_W) ? XW + PW : AW + 2 * FRAC_W) + 2;

    logic signed [PLW-1:0] pl_next;
    logic signed [PLW-1:0] pl_reg;
    logic signed [PHW-1:0] ph_next;
    logic signed [PHW-1:0] ph_reg;
    logic                  neg_reg;
    logic signed [AW-1:0]  add_reg;
    logic signed [SW-1:0]  rnd;
    logic signed [SW-1:0]  sum;
    logic signed [OW-1:0]  y_next;
    logic signed [OW-1:0]  y_reg;

    // Partial products: low half unsigned, high half signed
    assign pl_next = $signed({1'b0, x[LW-1:0]}) * p;
    assign ph_next = $signed(x[XW-1:LW]) * p;

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            neg_reg <= x[XW-1] ^ p[PW-1];
            add_reg <= addend;
        end
    end

    // Half minus one on negative products gives round-away; addend is an integer
    // coefficient, so it sits at the product's Q60 scale
    always_comb
    begin
        rnd    = neg_reg ? SW'(HALF_Q - 32'sd1) : SW'(HALF_Q);
        sum    = (SW'(ph_reg) <<< LW) + SW'(pl_reg) + (SW'(add_reg) <<< (2 * FRAC_W)) + rnd;
        y_next = sum[FRAC_W+OW-1:FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.fin)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// File: rtl/barometer_compensation.sv
// Top level of the barometer compensation pipeline: coefficient registers,
// polynomial stages and output. Depends on bcomp_pkg and all bcomp_* modules.
`default_nettype none

// Ten-stage pipeline that turns one raw pressure/temperature pair into
// compensated pressure (1/16 Pa) and temperature (1/256 degC). It takes one
// item every clock when the output is not held off; much of the depth is
// the chain of two dependent Q30 multiplies in the pressure polynomial,
// each spread over a partial-product stage and a rounding stage. Every
// stage has its own valid bit, so bubbles close up behind a stalled output
// and in_ready stays high while any stage is empty; in_ready depends
// combinationally on out_ready.
// Coefficients are written through the cfg port (index 0 holds c0 in bits
// 23:12 and c1 in bits 11:0) and must only change while the pipeline is
// empty; they reset to zero. Raw values are scaled to Q30 by 2^11/15, each
// Q30 product rounds to nearest with ties away from zero, and both outputs
// round the same way. Saturation is kept implicit: over the full range of
// inputs and coefficients the pressure stays within 26 bits and the
// temperature within 22 bits, so the clamps never bind.
module barometer_compensation (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [bcomp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bcomp_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [bcomp_pkg::RAW_W-1:0]     raw_pressure,
    input  logic signed [bcomp_pkg::RAW_W-1:0]     raw_temperature,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bcomp_pkg::PRES_W-1:0]    pressure_sixteenths_pa,
    output logic signed [bcomp_pkg::TEMP_W-1:0]    temperature_256ths_c
);
    import bcomp_pkg::*;

    // ---------------------------------------------------------------
    // Coefficient registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0]       tos_reg;
    logic signed [C20_W-1:0] c00_reg;
    logic signed [C20_W-1:0] c10_reg;
    logic signed [C16_W-1:0] c01_reg;
    logic signed [C16_W-1:0] c11_reg;
    logic signed [C16_W-1:0] c20_reg;
    logic signed [C16_W-1:0] c21_reg;
    logic signed [C16_W-1:0] c30_reg;
    logic signed [C12_W-1:0] c0;
    logic signed [C12_W-1:0] c1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tos_reg <= '0;
            c00_reg <= '0;
            c10_reg <= '0;
            c01_reg <= '0;
            c11_reg <= '0;
            c20_reg <= '0;
            c21_reg <= '0;
            c30_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TEMP_OFS_SLOPE: tos_reg <= cfg_data;
                CFG_PRES_OFFSET:    c00_reg <= cfg_data[C20_W-1:0];
                CFG_PRES_LINEAR:    c10_reg <= cfg_data[C20_W-1:0];
                CFG_TEMP_CROSS_LIN: c01_reg <= cfg_data[C16_W-1:0];
                CFG_CROSS_FIRST:    c11_reg <= cfg_data[C16_W-1:0];
                CFG_PRES_SQUARE:    c20_reg <= cfg_data[C16_W-1:0];
                CFG_CROSS_SECOND:   c21_reg <= cfg_data[C16_W-1:0];
                CFG_PRES_CUBE:      c30_reg <= cfg_data[C16_W-1:0];
                default:            ;
            endcase
        end
    end

    assign c0 = tos_reg[2*C12_W-1:C12_W];
    assign c1 = tos_reg[C12_W-1:0];

    // ---------------------------------------------------------------
    // Flow control: stage k loads on en[k]
    // ---------------------------------------------------------------
    logic [NSTG:1] en;

    bcomp_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .en        (en)
    );

    // ---------------------------------------------------------------
    // Stages 1-2: raw to Q30
    // ---------------------------------------------------------------
    logic signed [Q_W-1:0] ps2;
    logic signed [Q_W-1:0] ts2;

    bcomp_scale u_scale_p (
        .clk (clk),
        .en  ({en[1], en[2]}),
        .raw (raw_pressure),
        .q   (ps2)
    );

    bcomp_scale u_scale_t (
        .clk (clk),
        .en  ({en[1], en[2]}),
        .raw (raw_temperature),
        .q   (ts2)
    );

    // ---------------------------------------------------------------
    // Stage 3: first coefficient products
    // ---------------------------------------------------------------
    logic signed [Q_W-1:0]     ps3_reg;
    logic signed [Q_W-1:0]     ts3_reg;
    logic signed [S2_W-1:0]    p30_next;
    logic signed [S2_W-1:0]    p30_reg;
    logic signed [S2_W-1:0]    p21_next;
    logic signed [S2_W-1:0]    p21_reg;
    logic signed [TPROD_W-1:0] tprod_next;
    logic signed [TPROD_W-1:0] tprod_reg;

    assign p30_next   = c30_reg * ps2;
    assign p21_next   = c21_reg * ps2;
    assign tprod_next = c1 * ts2;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            ps3_reg   <= ps2;
            ts3_reg   <= ts2;
            p30_reg   <= p30_next;
            p21_reg   <= p21_next;
            tprod_reg <= tprod_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: innermost sums s2, r2 and the temperature accumulator
    // ---------------------------------------------------------------
    logic signed [Q_W-1:0]    ps4_reg;
    logic signed [Q_W-1:0]    ts4_reg;
    logic signed [S2_W-1:0]   s2_next;
    logic signed [S2_W-1:0]   s2_reg;
    logic signed [S2_W-1:0]   r2_next;
    logic signed [S2_W-1:0]   r2_reg;
    logic signed [TACC_W-1:0] tacc_next;
    logic signed [TACC_W-1:0] tacc_reg;

    assign s2_next   = (S2_W'(c20_reg) <<< FRAC_W) + p30_reg;
    assign r2_next   = (S2_W'(c11_reg) <<< FRAC_W) + p21_reg;
    assign tacc_next = (TACC_W'(c0) <<< T_C0_SH) + TACC_W'(tprod_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            ps4_reg  <= ps3_reg;
            ts4_reg  <= ts3_reg;
            s2_reg   <= s2_next;
            r2_reg   <= r2_next;
            tacc_reg <= tacc_next;
        end
    end

    // ---------------------------------------------------------------
    // Stages 5-6: s1 = c10 + s2*Ps, r1 = c01 + r2*Ps; temperature rounds in 5
    // ---------------------------------------------------------------
    logic signed [Q_W-1:0]    ps5_reg;
    logic signed [Q_W-1:0]    ts5_reg;
    logic signed [Q_W-1:0]    ps6_reg;
    logic signed [Q_W-1:0]    ts6_reg;
    logic signed [TACC_W-1:0] tsum;
    logic signed [TEMP_W-1:0] temp5_next;
    logic signed [TEMP_W-1:0] temp5_reg;
    logic signed [TEMP_W-1:0] temp6_reg;
    logic signed [S1_W-1:0]   s1;
    logic signed [R1_W-1:0]   r1;

    always_comb
    begin
        tsum = tacc_reg + (tacc_reg[TACC_W-1] ? TACC_W'(T_HALF - 32'sd1) : TACC_W'(T_HALF));
        temp5_next = TEMP_W'(tsum >>> T_SH);
    end

    bcomp_mulq30 #(
        .XW (S2_W),
        .PW (Q_W),
        .AW (C20_W),
        .OW (S1_W)
    ) u_mul_s1 (
        .clk    (clk),
        .en     ({en[5], en[6]}),
        .x      (s2_reg),
        .p      (ps4_reg),
        .addend (c10_reg),
        .y      (s1)
    );

    bcomp_mulq30 #(
        .XW (S2_W),
        .PW (Q_W),
        .AW (C16_W),
        .OW (R1_W)
    ) u_mul_r1 (
        .clk    (clk),
        .en     ({en[5], en[6]}),
        .x      (r2_reg),
        .p      (ps4_reg),
        .addend (c01_reg),
        .y      (r1)
    );

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            ps5_reg   <= ps4_reg;
            ts5_reg   <= ts4_reg;
            temp5_reg <= temp5_next;
        end
        if (en[6])
        begin
            ps6_reg   <= ps5_reg;
            ts6_reg   <= ts5_reg;
            temp6_reg <= temp5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stages 7-8: s0 = c00 + s1*Ps (c00 folded in), r0 = r1*Ts
    // ---------------------------------------------------------------
    logic signed [S0_W-1:0]   s0;
    logic signed [R0_W-1:0]   r0;
    logic signed [TEMP_W-1:0] temp7_reg;
    logic signed [TEMP_W-1:0] temp8_reg;

    bcomp_mulq30 #(
        .XW (S1_W),
        .PW (Q_W),
        .AW (C20_W),
        .OW (S0_W)
    ) u_mul_s0 (
        .clk    (clk),
        .en     ({en[7], en[8]}),
        .x      (s1),
        .p      (ps6_reg),
        .addend (c00_reg),
        .y      (s0)
    );

    bcomp_mulq30 #(
        .XW (R1_W),
        .PW (Q_W),
        .AW (1),
        .OW (R0_W)
    ) u_mul_r0 (
        .clk    (clk),
        .en     ({en[7], en[8]}),
        .x      (r1),
        .p      (ts6_reg),
        .addend (1'sb0),
        .y      (r0)
    );

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            temp7_reg <= temp6_reg;
        end
        if (en[8])
        begin
            temp8_reg <= temp7_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 9: final sum; stage 10: output rounding to 1/16 Pa
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0]  sum9_next;
    logic signed [SUM_W-1:0]  sum9_reg;
    logic signed [TEMP_W-1:0] temp9_reg;
    logic signed [SUM_W-1:0]  psum;
    logic signed [PRES_W-1:0] pres_next;
    logic signed [PRES_W-1:0] pres_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    assign sum9_next = SUM_W'(s0) + SUM_W'(r0);

    always_comb
    begin
        psum = sum9_reg + (sum9_reg[SUM_W-1] ? SUM_W'(P_HALF - 32'sd1) : SUM_W'(P_HALF));
        pres_next = PRES_W'(psum >>> P_SH);
    end

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            sum9_reg  <= sum9_next;
            temp9_reg <= temp8_reg;
        end
        if (en[10])
        begin
            pres_reg <= pres_next;
            temp_reg <= temp9_reg;
        end
    end

    assign pressure_sixteenths_pa = pres_reg;
    assign temperature_256ths_c   = temp_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // An empty output stage means every stage can load, so input must be open
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with output stage empty");

    // Pressure never needs more than 26 bits; wider means a width slip upstream
    a_pres_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pressure_sixteenths_pa[PRES_W-1:P_SH] == '0 ||
                       pressure_sixteenths_pa[PRES_W-1:P_SH] == '1))
        else $error("pressure result outside its arithmetic range");

    // Temperature never needs more than 22 bits
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature_256ths_c[TEMP_W-1:T_SH] == '0 ||
                       temperature_256ths_c[TEMP_W-1:T_SH] == '1))
        else $error("temperature result outside its arithmetic range");

endmodule

`default_nettype wire

// File: tb/barometer_compensation_tb.sv
// Self-checking bench for barometer_compensation: directed table, then random items per
// coefficient setting, every result checked against a fixed reading or a bit-exact
// behavioural predictor. Depends on bcomp_pkg and the barometer_compensation RTL only.

module barometer_compensation_tb;

    import bcomp_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no item moving on either side
    localparam int unsigned HOLD_CYCLES = 64;    // long output hold-off, well past pipe depth
    localparam int unsigned PHASE_ITEMS = 100;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PRINT_CAP   = 40;
    localparam longint      Q30_ONE     = 64'sd1073741824;

    localparam logic [RAW_W-1:0] RAW_MAX  = 24'h7FFFFF;
    localparam logic [RAW_W-1:0] RAW_MIN  = 24'h800000;
    localparam logic [RAW_W-1:0] RAW_NEG1 = 24'hFFFFFF;
    localparam logic [RAW_W-1:0] RAW_ONE  = 24'h000001;
    localparam logic [RAW_W-1:0] RAW_ZERO = 24'h000000;

    typedef struct packed {
        logic signed [RAW_W-1:0] pres;
        logic signed [RAW_W-1:0] temp;
    } raw_pair_t;

    typedef struct packed {
        logic signed [PRES_W-1:0] pres;
        logic signed [TEMP_W-1:0] temp;
    } reading_t;

    typedef struct {
        int unsigned set;
        raw_pair_t   raw;
        bit          known;
        reading_t    want;
    } stim_row_t;

    // Readings that follow straight from the coefficients, whatever the raws
    localparam reading_t READ_ZERO = '{pres: 32'sd0, temp: 24'sd0};
    localparam reading_t READ_HIGH = '{pres: 32'sd8388592, temp: 24'sd262016};
    localparam reading_t READ_LOW  = '{pres: -32'sd8388608, temp: -24'sd262144};
    localparam reading_t READ_TBD  = '0;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [RAW_W-1:0]  raw_pressure;
    logic signed [RAW_W-1:0]  raw_temperature;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [PRES_W-1:0] pressure_sixteenths_pa;
    logic signed [TEMP_W-1:0] temperature_256ths_c;

    // Mirror of the coefficient registers as written (slicing does the masking)
    logic [CFG_W-1:0] coef_mirror [8];
    logic [CFG_W-1:0] coef_next [8];

    reading_t    pending_readings [$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    logic        hold_req = 1'b0;
    logic        calm = 1'b0;

    // Coefficient sets for the directed table, in register order:
    // temp offset/slope, c00, c10, c01, c11, c20, c21, c30.
    // Set 0 is the reset state and is never written. Sets 1 and 2 carry junk
    // above each register's width, which must be dropped.
    logic [CFG_W-1:0] coef_sets [6][8] = '{
        '{24'h000000, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'h7FF000, 24'hA7FFFF, 24'hF00000, 24'hFF0000,
          24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000},
        '{24'h800000, 24'h380000, 24'h500000, 24'h120000,
          24'h340000, 24'h560000, 24'h780000, 24'h9A0000},
        '{24'h7FF7FF, 24'h07FFFF, 24'h07FFFF, 24'h007FFF,
          24'h007FFF, 24'h007FFF, 24'h007FFF, 24'h007FFF},
        '{24'h800800, 24'h080000, 24'h080000, 24'h008000,
          24'h008000, 24'h008000, 24'h008000, 24'h008000},
        '{24'h0C8EF9, 24'h013880, 24'h0F3CB0, 24'h00F448,
          24'h0004B0, 24'h00E4A8, 24'h000064, 24'h00FCE0}
    };

    stim_row_t plan [21] = '{
        // reset coefficients: everything reads zero, raws at zero and their extremes
        '{0, '{RAW_MAX, RAW_MAX}, 1'b1, READ_ZERO},
        '{0, '{RAW_MIN, RAW_MIN}, 1'b1, READ_ZERO},
        '{0, '{RAW_ZERO, RAW_ZERO}, 1'b1, READ_ZERO},
        '{0, '{RAW_MIN, RAW_MAX}, 1'b1, READ_ZERO},
        // largest offsets only
        '{1, '{24'h123456, 24'hFEDCBA}, 1'b1, READ_HIGH},
        '{1, '{RAW_MIN, RAW_MAX}, 1'b1, READ_HIGH},
        // most negative offsets only
        '{2, '{RAW_MAX, RAW_MIN}, 1'b1, READ_LOW},
        '{2, '{RAW_ONE, RAW_NEG1}, 1'b1, READ_LOW},
        // every coefficient at its positive limit
        '{3, '{RAW_MAX, RAW_MAX}, 1'b0, READ_TBD},
        '{3, '{RAW_MIN, RAW_MIN}, 1'b0, READ_TBD},
        '{3, '{RAW_MAX, RAW_MIN}, 1'b0, READ_TBD},
        '{3, '{RAW_MIN, RAW_MAX}, 1'b0, READ_TBD},
        '{3, '{RAW_ZERO, RAW_ZERO}, 1'b0, READ_TBD},
        // every coefficient at its negative limit
        '{4, '{RAW_MAX, RAW_MAX}, 1'b0, READ_TBD},
        '{4, '{RAW_MIN, RAW_MIN}, 1'b0, READ_TBD},
        '{4, '{RAW_MAX, RAW_MIN}, 1'b0, READ_TBD},
        '{4, '{RAW_MIN, RAW_MAX}, 1'b0, READ_TBD},
        '{4, '{RAW_ONE, RAW_NEG1}, 1'b0, READ_TBD},
        // sensor-like coefficients
        '{5, '{RAW_NEG1, RAW_ONE}, 1'b0, READ_TBD},
        '{5, '{24'h0A0000, 24'hF60000}, 1'b0, READ_TBD},
        '{5, '{24'h3FFFFF, 24'h400000}, 1'b0, READ_TBD}
    };

    barometer_compensation dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_write              (cfg_write),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .raw_pressure           (raw_pressure),
        .raw_temperature        (raw_temperature),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .pressure_sixteenths_pa (pressure_sixteenths_pa),
        .temperature_256ths_c   (temperature_256ths_c)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // round(raw * 2^11 / 15) to nearest; never a tie
    function automatic longint to_q30(logic signed [RAW_W-1:0] raw);
        longint v;
        longint q;
        v = raw;
        q = ((v < 0 ? -v : v) * 4096 + 15) / 30;
        return (v < 0) ? -q : q;
    endfunction

    // round(x * p / 2^30), ties away from zero, split so nothing overflows
    function automatic longint q30_mul(longint x, longint p);
        longint unsigned ux;
        longint unsigned up;
        longint unsigned r;
        ux = (x < 0) ? -x : x;
        up = (p < 0) ? -p : p;
        r = (ux >> 30) * up + (((ux & 64'h3FFF_FFFF) * up + 64'h2000_0000) >> 30);
        return ((x < 0) != (p < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // round(v / 2^n), ties away from zero
    function automatic longint round_shift(longint v, int unsigned n);
        longint unsigned u;
        longint unsigned r;
        u = (v < 0) ? -v : v;
        r = (u + (64'd1 << (n - 1))) >> n;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic reading_t compensate(raw_pair_t raw);
        longint   c0, c1, c00, c10, c01, c11, c20, c21, c30;
        longint   ps, ts, s2, s1, s0, r2, r1, r0, pv, tv;
        reading_t res;
        c0  = $signed(coef_mirror[CFG_TEMP_OFS_SLOPE][23:12]);
        c1  = $signed(coef_mirror[CFG_TEMP_OFS_SLOPE][11:0]);
        c00 = $signed(coef_mirror[CFG_PRES_OFFSET][C20_W-1:0]);
        c10 = $signed(coef_mirror[CFG_PRES_LINEAR][C20_W-1:0]);
        c01 = $signed(coef_mirror[CFG_TEMP_CROSS_LIN][C16_W-1:0]);
        c11 = $signed(coef_mirror[CFG_CROSS_FIRST][C16_W-1:0]);
        c20 = $signed(coef_mirror[CFG_PRES_SQUARE][C16_W-1:0]);
        c21 = $signed(coef_mirror[CFG_CROSS_SECOND][C16_W-1:0]);
        c30 = $signed(coef_mirror[CFG_PRES_CUBE][C16_W-1:0]);
        ps = to_q30(raw.pres);
        ts = to_q30(raw.temp);
        // pressure: Horner in Ps, then the temperature cross terms
        s2 = c20 * Q30_ONE + c30 * ps;
        s1 = c10 * Q30_ONE + q30_mul(s2, ps);
        s0 = q30_mul(s1, ps);
        r2 = c11 * Q30_ONE + c21 * ps;
        r1 = c01 * Q30_ONE + q30_mul(r2, ps);
        r0 = q30_mul(r1, ts);
        pv = round_shift(c00 * Q30_ONE + s0 + r0, 26);
        if (pv > 64'sd2147483647)
            pv = 64'sd2147483647;
        if (pv < -64'sd2147483648)
            pv = -64'sd2147483648;
        // temperature: 0.5*c0 in 1/256 degC is c0*128, held at 2^22 scale
        tv = round_shift(c0 * 64'sd536870912 + c1 * ts, 22);
        if (tv > 64'sd8388607)
            tv = 64'sd8388607;
        if (tv < -64'sd8388608)
            tv = -64'sd8388608;
        res.pres = PRES_W'(pv);
        res.temp = TEMP_W'(tv);
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, longint got, longint want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Results are taken at the rising edge, oldest expectation first
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                flag_mismatch("result with no item outstanding, pressure",
                              pressure_sixteenths_pa, 0);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (pressure_sixteenths_pa !== want.pres)
                    flag_mismatch("pressure", pressure_sixteenths_pa, want.pres);
                if (temperature_256ths_c !== want.temp)
                    flag_mismatch("temperature", temperature_256ths_c, want.temp);
            end
        end
    end

    // Watchdog: too long with no item moving on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Random stalls, one long hold-off on request, and none at all once
    // the final phase has begun.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- sender

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return RAW_MAX;
                    1: return RAW_MIN;
                    2: return RAW_ZERO;
                    3: return RAW_NEG1;
                    default: return RAW_ONE;
                endcase
            end
            1: return RAW_W'($urandom_range(0, 4095)) - 24'd2048;   // near zero
            default: return RAW_W'($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge with in_valid
    // possibly still high, so the next call keeps the item stream going.
    task automatic offer(raw_pair_t raw, bit known, reading_t want, bit may_pause);
        in_valid        = 1'b1;
        raw_pressure    = raw.pres;
        raw_temperature = raw.temp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_readings.push_back(known ? want : compensate(raw));
        @(negedge clk);
        if (may_pause && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle();
        in_valid = 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
    endtask

    // Write all eight registers back to back; only called with the pipe empty
    task automatic commit_coefs();
        for (int i = 0; i < 8; i++)
        begin
            cfg_write      = 1'b1;
            cfg_index      = cfg_idx_t'(i);
            cfg_data       = coef_next[i];
            coef_mirror[i] = coef_next[i];
            @(negedge clk);
        end
        cfg_write = 1'b0;
    endtask

    initial
    begin
        raw_pair_t   rp;
        bit          stress;
        int unsigned applied;

        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_TEMP_OFS_SLOPE;
        cfg_data        = '0;
        in_valid        = 1'b0;
        raw_pressure    = '0;
        raw_temperature = '0;
        foreach (coef_mirror[k])
            coef_mirror[k] = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table; a new coefficient set is loaded once the pipe drains
        applied = 0;
        foreach (plan[i])
        begin
            if (plan[i].set != applied)
            begin
                settle();
                coef_next = coef_sets[plan[i].set];
                commit_coefs();
                applied = plan[i].set;
            end
            offer(plan[i].raw, plan[i].known, plan[i].want, 1'b1);
        end

        // Random phases, each with fresh coefficients.
        // Phase 2: long output hold-off while items keep coming back to back.
        // Phase 3: a mid-phase pause until every result is home.
        // Last phase: no idling on either side.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            foreach (coef_next[k])
                coef_next[k] = ($urandom_range(0, 7) == 0) ? '0 : CFG_W'($urandom());
            commit_coefs();
            calm <= (phase == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                stress = (phase == 2 && n >= 30 && n < 70);
                if (phase == 2 && n == 30)
                    hold_req <= 1'b1;
                if (phase == 3 && n == 50)
                    settle();
                rp.pres = pick_raw();
                rp.temp = pick_raw();
                offer(rp, 1'b0, READ_TBD, !stress && phase != PHASES - 1);
            end
        end

        settle();
        repeat (2 * NSTG) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/bcomp_pkg.sv
rtl/bcomp_flow.sv
rtl/bcomp_scale.sv
rtl/bcomp_mulq30.sv
rtl/barometer_compensation.sv
tb/barometer_compensation_tb.sv
